/* rtl/core/dtsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time set controller package
// Key and mode codes, the edit word, field limits and the field step helpers.
// ----------------------------------------------------------------------------
package dtsc_pkg;

	typedef enum logic [1:0] {
		KEY_NEXT   = 2'd0,
		KEY_UP     = 2'd1,
		KEY_DOWN   = 2'd2,
		KEY_CANCEL = 2'd3
	} key_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_YEAR   = 3'd1,
		MODE_MONTH  = 3'd2,
		MODE_DAY    = 3'd3,
		MODE_HOUR   = 3'd4,
		MODE_MINUTE = 3'd5,
		MODE_SECOND = 3'd6
	} mode_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} edit_t;

	// Field limits, all carried at the widest field width
	localparam logic [6:0] YEAR_MIN  = 7'd0;
	localparam logic [6:0] YEAR_MAX  = 7'd99;
	localparam logic [6:0] MONTH_MIN = 7'd1;
	localparam logic [6:0] MONTH_MAX = 7'd12;
	localparam logic [6:0] DAY_MIN   = 7'd1;
	localparam logic [6:0] HOUR_MIN  = 7'd0;
	localparam logic [6:0] HOUR_MAX  = 7'd23;
	localparam logic [6:0] MS_MIN    = 7'd0;
	localparam logic [6:0] MS_MAX    = 7'd59;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;

	// Step a field up or down with wraparound; out-of-range values snap to a limit
	function automatic logic [6:0] step_field(logic [6:0] v, logic up,
			logic [6:0] lo, logic [6:0] hi);
		logic [6:0] res;
		if (up) begin
			res = (v >= hi) ? lo : v + 7'd1;
		end else begin
			res = (v <= lo || v > hi) ? hi : v - 7'd1;
		end
		return res;
	endfunction

	// Month length; February is a leap month when the year is a multiple of four
	function automatic logic [4:0] days_in_month(logic [3:0] month, logic [6:0] year);
		logic [4:0] res;
		if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
				month == MONTH_NOV) begin
			res = 5'd30;
		end else if (month == MONTH_FEB) begin
			res = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end else begin
			res = 5'd31;
		end
		return res;
	endfunction

endpackage

/* rtl/core/dtsc_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time set controller channels
// Key word in (key plus running clock) and result word out (mode, edit
// values, commit strobe), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dtsc_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] key;
	logic [6:0] now_year;
	logic [3:0] now_month;
	logic [4:0] now_day;
	logic [4:0] now_hour;
	logic [5:0] now_minute;
	logic [5:0] now_second;

	modport source (
		output valid, key, now_year, now_month, now_day, now_hour, now_minute,
			now_second,
		input  ready
	);
	modport sink (
		input  valid, key, now_year, now_month, now_day, now_hour, now_minute,
			now_second,
		output ready
	);
endinterface

interface dtsc_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [6:0] edit_year;
	logic [3:0] edit_month;
	logic [4:0] edit_day;
	logic [4:0] edit_hour;
	logic [5:0] edit_minute;
	logic [5:0] edit_second;
	logic       commit;

	modport source (
		output valid, mode, edit_year, edit_month, edit_day, edit_hour, edit_minute,
			edit_second, commit,
		input  ready
	);
	modport sink (
		input  valid, mode, edit_year, edit_month, edit_day, edit_hour, edit_minute,
			edit_second, commit,
		output ready
	);
endinterface

/* rtl/core/dtsc_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time set controller update logic
// Next mode, next edit values and commit strobe for one key word.
// ----------------------------------------------------------------------------
module dtsc_update (
	input  dtsc_pkg::mode_t mode,
	input  dtsc_pkg::edit_t cur,
	input  dtsc_pkg::key_t  key,
	input  dtsc_pkg::edit_t now,
	output dtsc_pkg::mode_t mode_nxt,
	output dtsc_pkg::edit_t edit_nxt,
	output logic            commit
);

	logic       up;
	logic [4:0] day_max;
	logic [6:0] year_st;
	logic [6:0] month_st;
	logic [6:0] day_st;
	logic [6:0] hour_st;
	logic [6:0] minute_st;
	logic [6:0] second_st;

	// Candidate step of every field; the mode picks one
	assign up        = (key == dtsc_pkg::KEY_UP);
	assign day_max   = dtsc_pkg::days_in_month(cur.month, cur.year);
	assign year_st   = dtsc_pkg::step_field(cur.year, up, dtsc_pkg::YEAR_MIN,
		dtsc_pkg::YEAR_MAX);
	assign month_st  = dtsc_pkg::step_field({3'b000, cur.month}, up, dtsc_pkg::MONTH_MIN,
		dtsc_pkg::MONTH_MAX);
	assign day_st    = dtsc_pkg::step_field({2'b00, cur.day}, up, dtsc_pkg::DAY_MIN,
		{2'b00, day_max});
	assign hour_st   = dtsc_pkg::step_field({2'b00, cur.hour}, up, dtsc_pkg::HOUR_MIN,
		dtsc_pkg::HOUR_MAX);
	assign minute_st = dtsc_pkg::step_field({1'b0, cur.minute}, up, dtsc_pkg::MS_MIN,
		dtsc_pkg::MS_MAX);
	assign second_st = dtsc_pkg::step_field({1'b0, cur.second}, up, dtsc_pkg::MS_MIN,
		dtsc_pkg::MS_MAX);

	// Decode the key against the current mode
	always_comb begin
		mode_nxt = mode;
		edit_nxt = cur;
		commit   = 1'b0;
		if (mode == dtsc_pkg::MODE_IDLE) begin
			// load the running clock on next; ignore other keys
			if (key == dtsc_pkg::KEY_NEXT) begin
				edit_nxt = now;
				mode_nxt = dtsc_pkg::MODE_YEAR;
			end
		end else if (key == dtsc_pkg::KEY_CANCEL) begin
			mode_nxt = dtsc_pkg::MODE_IDLE;
		end else if (key == dtsc_pkg::KEY_NEXT) begin
			if (mode == dtsc_pkg::MODE_SECOND) begin
				commit   = 1'b1;
				mode_nxt = dtsc_pkg::MODE_IDLE;
			end else begin
				mode_nxt = dtsc_pkg::mode_t'(mode + 3'd1);
			end
		end else begin
			case (mode)
				dtsc_pkg::MODE_YEAR:   edit_nxt.year   = year_st;
				dtsc_pkg::MODE_MONTH:  edit_nxt.month  = month_st[3:0];
				dtsc_pkg::MODE_DAY:    edit_nxt.day    = day_st[4:0];
				dtsc_pkg::MODE_HOUR:   edit_nxt.hour   = hour_st[4:0];
				dtsc_pkg::MODE_MINUTE: edit_nxt.minute = minute_st[5:0];
				dtsc_pkg::MODE_SECOND: edit_nxt.second = second_st[5:0];
				default: begin
					edit_nxt = cur;
				end
			endcase
		end
	end

endmodule

/* rtl/core/date_time_set_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date/time set controller
// Key-driven editor for year, month, day, hour, minute and second, with a
// commit strobe that loads the edited time into the running clock.
// Path: a key word is registered in the input stage, then updates the mode and
// edit registers as it enters the output stage, where the result word waits.
// Throughput: 1 key word per cycle while the result side takes words, set by
// the update of the mode and edit registers as words pass to the output stage.
// Reset: arst_n clears the mode to idle, the edit registers to 00-01-01
// 00:00:00 and both stages to empty.
// ----------------------------------------------------------------------------
module date_time_set_controller (
	input  logic       clk,
	input  logic       arst_n,
	dtsc_cmd_if.sink   cmd,
	dtsc_res_if.source res
);

	// Input stage
	logic            valid_s1;
	dtsc_pkg::key_t  key_s1;
	dtsc_pkg::edit_t now_s1;

	// Edit state
	dtsc_pkg::mode_t mode_q;
	dtsc_pkg::edit_t edit_q;

	// Output stage
	logic            valid_s2;
	dtsc_pkg::mode_t mode_s2;
	dtsc_pkg::edit_t edit_s2;
	logic            commit_s2;

	dtsc_pkg::mode_t mode_nxt;
	dtsc_pkg::edit_t edit_nxt;
	logic            commit_nxt;
	logic            out_free;
	logic            adv;

	// Move the staged word on when the output stage is empty or being drained
	assign out_free  = !valid_s2 || res.ready;
	assign adv       = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	// Capture the key word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			key_s1        <= dtsc_pkg::key_t'(cmd.key);
			now_s1.year   <= cmd.now_year;
			now_s1.month  <= cmd.now_month;
			now_s1.day    <= cmd.now_day;
			now_s1.hour   <= cmd.now_hour;
			now_s1.minute <= cmd.now_minute;
			now_s1.second <= cmd.now_second;
		end
	end

	dtsc_update u_update (
		.mode     (mode_q),
		.cur      (edit_q),
		.key      (key_s1),
		.now      (now_s1),
		.mode_nxt (mode_nxt),
		.edit_nxt (edit_nxt),
		.commit   (commit_nxt)
	);

	// Advance the edit state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= dtsc_pkg::MODE_IDLE;
			edit_q.year   <= 7'd0;
			edit_q.month  <= 4'd1;
			edit_q.day    <= 5'd1;
			edit_q.hour   <= 5'd0;
			edit_q.minute <= 6'd0;
			edit_q.second <= 6'd0;
		end else if (adv) begin
			mode_q <= mode_nxt;
			edit_q <= edit_nxt;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2   <= mode_nxt;
			edit_s2   <= edit_nxt;
			commit_s2 <= commit_nxt;
		end
	end

	assign res.valid       = valid_s2;
	assign res.mode        = mode_s2;
	assign res.edit_year   = edit_s2.year;
	assign res.edit_month  = edit_s2.month;
	assign res.edit_day    = edit_s2.day;
	assign res.edit_hour   = edit_s2.hour;
	assign res.edit_minute = edit_s2.minute;
	assign res.edit_second = edit_s2.second;
	assign res.commit      = commit_s2;

	// Commit only leaves second edit
	a_commit_from_second: assert property (@(posedge clk) disable iff (!arst_n)
		adv && commit_nxt |-> mode_q == dtsc_pkg::MODE_SECOND)
		else $error("commit raised outside second edit");

	// A committed result word always reports idle
	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && commit_s2 |-> mode_s2 == dtsc_pkg::MODE_IDLE)
		else $error("commit word not in idle mode");

	// Cancel always returns to idle
	a_cancel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && key_s1 == dtsc_pkg::KEY_CANCEL |=> mode_q == dtsc_pkg::MODE_IDLE)
		else $error("cancel did not return to idle");

	// Keys other than next leave idle state and edit values alone
	a_idle_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		adv && mode_q == dtsc_pkg::MODE_IDLE && key_s1 != dtsc_pkg::KEY_NEXT
		|=> $stable(edit_q) && mode_q == dtsc_pkg::MODE_IDLE)
		else $error("idle state changed on an ignored key");

	// State only moves when a word enters the output stage
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(edit_q) && $stable(mode_q))
		else $error("edit state changed without an advancing word");

endmodule
